// ----- rtl/hse_pkg.sv -----
// shared types, constants and functions for the sha-256 hash engine
`default_nettype none

package hse_pkg;

    // input word: one message byte and its flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } hse_in_t;

    // output word: one digest word with its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } hse_out_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_EMIT
    } hse_state_t;

    // controls from the sequencer to the round datapath
    typedef struct packed {
        logic       init_chain;
        logic       load_vars;
        logic       do_round;
        logic       finish;
        logic [5:0] round_num;
    } hse_ctrl_t;

    typedef logic [7:0][31:0] hse_chain_t;

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [5:0]  LEN_START = 6'd56;
    localparam logic [5:0]  LAST_FILL = 6'd63;
    localparam logic [3:0]  LEN_BYTES = 4'd8;

    // initial hash value, word 0 first
    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] r;
        unique case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // round constants
    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] r;
        unique case (t)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hse_msg_buf.sv -----
// block buffer memory: 16 big-endian message words, one write and one read port
`default_nettype none

module hse_msg_buf (
    input  wire logic        clk,
    input  wire logic        wr_en,
    input  wire logic [3:0]  wr_addr,
    input  wire logic [31:0] wr_data,
    input  wire logic [3:0]  rd_addr,
    output logic      [31:0] rd_data
);

    logic [31:0] mem [16];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/hse_round.sv -----
// compression datapath: working variables, schedule window and chain value
`default_nettype none

module hse_round (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hse_pkg::hse_ctrl_t ctrl,
    input  wire logic [31:0]       mem_word,
    output hse_pkg::hse_chain_t    chain
);

    hse_pkg::hse_chain_t chain_reg;
    hse_pkg::hse_chain_t chain_next;
    logic [31:0] var_reg [8];
    logic [31:0] var_next [8];
    logic [31:0] sched_reg [16];
    logic [31:0] sched_next [16];

    logic [31:0] w, g0, g1, s0, s1, ch, maj, t1, t2, e, a;

    // message schedule word for this round
    always_comb
    begin
        g0 = {sched_reg[1][6:0], sched_reg[1][31:7]}
           ^ {sched_reg[1][17:0], sched_reg[1][31:18]}
           ^ (sched_reg[1] >> 3);
        g1 = {sched_reg[14][16:0], sched_reg[14][31:17]}
           ^ {sched_reg[14][18:0], sched_reg[14][31:19]}
           ^ (sched_reg[14] >> 10);
        if (ctrl.round_num[5:4] == 2'd0)
        begin
            w = mem_word;
        end
        else
        begin
            w = sched_reg[0] + g0 + sched_reg[9] + g1;
        end
    end

    // round function
    always_comb
    begin
        e   = var_reg[4];
        a   = var_reg[0];
        s1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        ch  = (e & var_reg[5]) ^ (~e & var_reg[6]);
        t1  = var_reg[7] + s1 + ch + hse_pkg::round_k(ctrl.round_num) + w;
        s0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        maj = (a & var_reg[1]) ^ (a & var_reg[2]) ^ (var_reg[1] & var_reg[2]);
        t2  = s0 + maj;
    end

    // next values of the datapath registers
    always_comb
    begin
        chain_next = chain_reg;
        for (int j = 0; j < 8; j++)
        begin
            var_next[j] = var_reg[j];
        end
        for (int j = 0; j < 16; j++)
        begin
            sched_next[j] = sched_reg[j];
        end
        if (ctrl.init_chain)
        begin
            for (int j = 0; j < 8; j++)
            begin
                chain_next[j] = hse_pkg::init_h(3'(j));
            end
        end
        else if (ctrl.finish)
        begin
            for (int j = 0; j < 8; j++)
            begin
                chain_next[j] = chain_reg[j] + var_reg[j];
            end
        end
        if (ctrl.load_vars)
        begin
            for (int j = 0; j < 8; j++)
            begin
                var_next[j] = chain_reg[j];
            end
        end
        else if (ctrl.do_round)
        begin
            var_next[7] = var_reg[6];
            var_next[6] = var_reg[5];
            var_next[5] = var_reg[4];
            var_next[4] = var_reg[3] + t1;
            var_next[3] = var_reg[2];
            var_next[2] = var_reg[1];
            var_next[1] = var_reg[0];
            var_next[0] = t1 + t2;
            for (int j = 0; j < 15; j++)
            begin
                sched_next[j] = sched_reg[j + 1];
            end
            sched_next[15] = w;
        end
    end

    // chain value resets to the initial hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 8; j++)
            begin
                chain_reg[j] <= hse_pkg::init_h(3'(j));
            end
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        var_reg   <= var_next;
        sched_reg <= sched_next;
    end

    assign chain = chain_reg;

endmodule

`default_nettype wire

// ----- rtl/sha256_hash_engine_top.sv -----
// streaming sha-256 engine: byte intake, padding, round sequencer and digest output
//
//  channel  dir  handshake             word
//  data     in   data_valid/data_stall    hse_in_t  (byte, byte flag, end flag)
//  digest   out  digest_valid/digest_stall hse_out_t (digest word, index, last)
//
//  a byte word is taken while the sequencer is idle; the 64th byte of a block starts
//  the compression (one load step, 64 rounds at one per cycle, one chain update).
//  an end word pads one byte per cycle up to the block end, then compresses once
//  or twice and hands out eight digest words, one per cycle when not stalled.
//  reset gives the initial hash value, an empty buffer and a zero bit count.
//  data_stall is high whenever the sequencer is not idle; digest stall holds the
//  output register and pauses digest delivery.
`default_nettype none

module sha256_hash_engine_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              data_valid,
    output logic                   data_stall,
    input  wire hse_pkg::hse_in_t  data,
    output logic                   digest_valid,
    input  wire logic              digest_stall,
    output hse_pkg::hse_out_t      digest
);

    hse_pkg::hse_state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [23:0] asm_reg, asm_next;
    logic        pad_reg, pad_next;
    logic        sent80_reg, sent80_next;
    logic [3:0]  len_reg, len_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  emit_reg, emit_next;
    logic        ovalid_reg, ovalid_next;
    hse_pkg::hse_out_t oword_reg, oword_next;

    hse_pkg::hse_ctrl_t  ctrl;
    hse_pkg::hse_chain_t chain;
    logic        accept;
    logic        absorb;
    logic [7:0]  absorb_byte;
    logic        wr_en;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    logic [7:0]  len_byte;
    logic        out_free;

    assign accept   = data_valid && !data_stall;
    assign out_free = !ovalid_reg || !digest_stall;
    assign len_byte = bits_reg[{3'd7 - len_reg[2:0], 3'b000} +: 8];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hse_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (data.byte_present && fill_reg == hse_pkg::LAST_FILL)
                    begin
                        state_next = hse_pkg::ST_LOAD;
                    end
                    else if (data.end_of_message)
                    begin
                        state_next = hse_pkg::ST_PAD;
                    end
                end
            end
            hse_pkg::ST_PAD:
            begin
                if (fill_reg == hse_pkg::LAST_FILL)
                begin
                    state_next = hse_pkg::ST_LOAD;
                end
            end
            hse_pkg::ST_LOAD:
            begin
                state_next = hse_pkg::ST_ROUND;
            end
            hse_pkg::ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = hse_pkg::ST_FINISH;
                end
            end
            hse_pkg::ST_FINISH:
            begin
                priority if (!pad_reg)
                begin
                    state_next = hse_pkg::ST_IDLE;
                end
                else if (len_reg == hse_pkg::LEN_BYTES)
                begin
                    state_next = hse_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = hse_pkg::ST_PAD;
                end
            end
            hse_pkg::ST_EMIT:
            begin
                if (out_free && emit_reg == 3'd7)
                begin
                    state_next = hse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hse_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        data_stall  = (state_reg != hse_pkg::ST_IDLE);
        absorb      = 1'b0;
        absorb_byte = data.data_byte;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        asm_next    = asm_reg;
        pad_next    = pad_reg;
        sent80_next = sent80_reg;
        len_next    = len_reg;
        rnd_next    = rnd_reg;
        emit_next   = emit_reg;
        ovalid_next = ovalid_reg && digest_stall;
        oword_next  = oword_reg;
        rd_addr     = 4'd0;
        ctrl        = '0;
        ctrl.round_num = rnd_reg;

        unique case (state_reg)
            hse_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    absorb = data.byte_present;
                    if (data.byte_present)
                    begin
                        bits_next = bits_reg + 64'd8;
                    end
                    pad_next = data.end_of_message;
                end
            end
            hse_pkg::ST_PAD:
            begin
                absorb = 1'b1;
                priority if (!sent80_reg)
                begin
                    absorb_byte = hse_pkg::PAD_BYTE;
                    sent80_next = 1'b1;
                end
                else if (len_reg == 4'd0 && fill_reg != hse_pkg::LEN_START)
                begin
                    absorb_byte = 8'h00;
                end
                else
                begin
                    absorb_byte = len_byte;
                    len_next    = len_reg + 4'd1;
                end
            end
            hse_pkg::ST_LOAD:
            begin
                ctrl.load_vars = 1'b1;
                rnd_next       = 6'd0;
            end
            hse_pkg::ST_ROUND:
            begin
                ctrl.do_round = 1'b1;
                rd_addr       = rnd_reg[3:0] + 4'd1;
                rnd_next      = rnd_reg + 6'd1;
            end
            hse_pkg::ST_FINISH:
            begin
                ctrl.finish = 1'b1;
                emit_next   = 3'd0;
            end
            hse_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next            = 1'b1;
                    oword_next.digest_word = chain[emit_reg];
                    oword_next.word_index  = emit_reg;
                    oword_next.last_word   = (emit_reg == 3'd7);
                    emit_next              = emit_reg + 3'd1;
                    if (emit_reg == 3'd7)
                    begin
                        ctrl.init_chain = 1'b1;
                        bits_next       = 64'd0;
                        pad_next        = 1'b0;
                        sent80_next     = 1'b0;
                        len_next        = 4'd0;
                    end
                end
            end
            default:
            begin
                data_stall = 1'b1;
            end
        endcase

        // byte intake shared by message and padding bytes
        if (absorb)
        begin
            asm_next  = {asm_reg[15:0], absorb_byte};
            fill_next = fill_reg + 6'd1;
        end
    end

    assign wr_en = absorb && (fill_reg[1:0] == 2'd3);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hse_pkg::ST_IDLE;
            fill_reg   <= 6'd0;
            bits_reg   <= 64'd0;
            pad_reg    <= 1'b0;
            sent80_reg <= 1'b0;
            len_reg    <= 4'd0;
            rnd_reg    <= 6'd0;
            emit_reg   <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            pad_reg    <= pad_next;
            sent80_reg <= sent80_next;
            len_reg    <= len_next;
            rnd_reg    <= rnd_next;
            emit_reg   <= emit_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        asm_reg   <= asm_next;
        oword_reg <= oword_next;
    end

    // block buffer
    hse_msg_buf u_msg_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[5:2]),
        .wr_data ({asm_reg, absorb_byte}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // compression datapath
    hse_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .mem_word (rd_data),
        .chain    (chain)
    );

    assign digest_valid = ovalid_reg;
    assign digest       = oword_reg;

endmodule

`default_nettype wire
